// ===== src/smo_pkg.sv =====
`default_nettype none
package smo_pkg;

	localparam int SpeedWindow = 32;
	localparam int CordicSteps = 15;

	localparam logic [2:0] REG_F_GAIN      = 3'd0;
	localparam logic [2:0] REG_G_GAIN      = 3'd1;
	localparam logic [2:0] REG_SLIDE_GAIN  = 3'd2;
	localparam logic [2:0] REG_MAX_ERROR   = 3'd3;
	localparam logic [2:0] REG_LINEAR_GAIN = 3'd4;
	localparam logic [2:0] REG_MIN_COEF    = 3'd5;
	localparam logic [2:0] REG_THETA_OFS   = 3'd6;
	localparam logic [2:0] REG_SPEED_COEF  = 3'd7;

	function automatic logic [13:0] atan_lut(input logic [3:0] i);
		case (i)
			4'd0:  atan_lut = 14'd8192;
			4'd1:  atan_lut = 14'd4836;
			4'd2:  atan_lut = 14'd2555;
			4'd3:  atan_lut = 14'd1297;
			4'd4:  atan_lut = 14'd651;
			4'd5:  atan_lut = 14'd326;
			4'd6:  atan_lut = 14'd163;
			4'd7:  atan_lut = 14'd81;
			4'd8:  atan_lut = 14'd41;
			4'd9:  atan_lut = 14'd20;
			4'd10: atan_lut = 14'd10;
			4'd11: atan_lut = 14'd5;
			4'd12: atan_lut = 14'd3;
			4'd13: atan_lut = 14'd1;
			4'd14: atan_lut = 14'd1;
			default: atan_lut = 14'd0;
		endcase
	endfunction

endpackage
`default_nettype wire

// ===== src/smo_qmul.sv =====
`default_nettype none
// Q15 product (a*b)>>15 floor, wrapped to 16 bits; registered result.
module smo_qmul (
	input  wire logic               clk,
	input  wire logic signed [16:0] a,
	input  wire logic signed [16:0] b,
	output logic signed [15:0]      p_q
);
	logic signed [33:0] prod;

	assign prod = a * b;

	always_ff @(posedge clk) begin
		p_q <= prod[30:15];
	end
endmodule
`default_nettype wire

// ===== src/sliding_mode_rotor_angle_observer_unit.sv =====
`default_nettype none
// Sliding-mode rotor angle observer, Q15. One item (v_alpha, v_beta, i_alpha, i_beta) in,
// one result (angle, speed_filtered, emf_alpha, emf_beta) out. All products run through
// one shared 17x17 multiplier with a registered product under a sequencer, and the atan2
// is a 15-step CORDIC on one shared add/shift unit, one step per cycle. Each axis whose error
// lands in the linear sliding region takes an extra multiply (A_LIN/B_LIN, then A_SL/B_SL)
// before the result, and the input is not ready again until the cycle after the result has
// been taken.
module sliding_mode_rotor_angle_observer_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// v_alpha[15:0], v_beta[31:16], i_alpha[47:32], i_beta[63:48]
	input  wire logic [63:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// angle[15:0], speed_filtered[31:16], emf_alpha[47:32], emf_beta[63:48]
	output logic [63:0]      m_tdata,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_idx,
	input  wire logic [15:0] cfg_data
);
	import smo_pkg::*;

	typedef enum logic [4:0] {
		IDLE, A_FI, A_GD, A_SUM, A_LIN, A_SL,
		B_FI, B_GD, B_SUM, B_LIN, B_SL,
		E1A, E1A_W, E2A, E2A_W, E1B, E1B_W, E2B, E2B_W,
		COR_INIT, COR, SPD, SPD_W, SPF, SPF_W, CO, CO_W, DONE
	} state_t;

	state_t state_q;
	logic [14:0] f_q, g_q, sg_q, me_q, lg_q, mc_q, sc_q;
	logic signed [15:0] to_q;
	logic signed [15:0] va_q, vb_q, ia_q, ib_q;
	logic signed [15:0] est_a_q, est_b_q, sl_a_q, sl_b_q;
	logic signed [15:0] e1a_q, e1b_q, e2a_q, e2b_q;
	logic signed [15:0] spr_q, splp_q, coef_q, last_q, asum_q;
	logic [15:0] win_q;
	logic signed [15:0] tmp_q, theta_q;
	logic signed [17:0] cx_q, cy_q;
	logic [15:0] cz_q;
	logic [3:0] ci_q;
	logic signed [16:0] ma, mb;
	logic signed [15:0] mp;

	smo_qmul u_mul (.clk(clk), .a(ma), .b(mb), .p_q(mp));

	logic signed [15:0] err_a, err_b, sum16, dtheta, nsum;
	logic signed [16:0] neg_me;
	logic signed [17:0] dx, dy;

	assign neg_me = -$signed({2'b00, me_q});
	assign sum16  = tmp_q + mp;
	assign err_a  = sum16 - ia_q;
	assign err_b  = sum16 - ib_q;
	assign dx     = cy_q >>> ci_q;
	assign dy     = cx_q >>> ci_q;
	assign dtheta = theta_q - last_q;
	assign nsum   = asum_q + dtheta;

	always_comb begin
		ma = 17'sd0;
		mb = 17'sd0;
		case (state_q)
			A_FI: begin ma = {2'b00, f_q}; mb = 17'(est_a_q); end
			A_GD: begin ma = {2'b00, g_q}; mb = 17'(16'(va_q - e1a_q - sl_a_q)); end
			A_LIN: begin ma = {2'b00, lg_q}; mb = 17'(tmp_q); end
			B_FI: begin ma = {2'b00, f_q}; mb = 17'(est_b_q); end
			B_GD: begin ma = {2'b00, g_q}; mb = 17'(16'(vb_q - e1b_q - sl_b_q)); end
			B_LIN: begin ma = {2'b00, lg_q}; mb = 17'(tmp_q); end
			E1A: begin ma = 17'(coef_q); mb = 17'(16'(sl_a_q - e1a_q)); end
			E2A: begin ma = 17'(coef_q); mb = 17'(16'(e1a_q - e2a_q)); end
			E1B: begin ma = 17'(coef_q); mb = 17'(16'(sl_b_q - e1b_q)); end
			E2B: begin ma = 17'(coef_q); mb = 17'(16'(e1b_q - e2b_q)); end
			SPF: begin ma = {2'b00, mc_q}; mb = 17'(16'(spr_q - splp_q)); end
			CO: begin
				ma = splp_q[15] ? -17'(splp_q) : 17'(splp_q);
				mb = {2'b00, sc_q};
			end
			default: ;
		endcase
	end

	assign s_tready = (state_q == IDLE);
	assign m_tvalid = (state_q == DONE);
	assign m_tdata  = {e2b_q, e2a_q, splp_q, 16'(theta_q + to_q)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			f_q <= 15'd32767; g_q <= 15'd32767; sg_q <= 15'd16384; me_q <= 15'd4096;
			lg_q <= 15'd32767; mc_q <= 15'd256; to_q <= 16'sd16384; sc_q <= 15'd1024;
			est_a_q <= '0; est_b_q <= '0; sl_a_q <= '0; sl_b_q <= '0;
			e1a_q <= '0; e1b_q <= '0; e2a_q <= '0; e2b_q <= '0;
			spr_q <= '0; splp_q <= '0; coef_q <= 16'sd256; last_q <= '0;
			asum_q <= '0; win_q <= '0; theta_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_F_GAIN:      f_q  <= cfg_data[14:0];
					REG_G_GAIN:      g_q  <= cfg_data[14:0];
					REG_SLIDE_GAIN:  sg_q <= cfg_data[14:0];
					REG_MAX_ERROR:   me_q <= cfg_data[14:0];
					REG_LINEAR_GAIN: lg_q <= cfg_data[14:0];
					REG_MIN_COEF:    mc_q <= cfg_data[14:0];
					REG_THETA_OFS:   to_q <= cfg_data;
					REG_SPEED_COEF:  sc_q <= cfg_data[14:0];
					default: ;
				endcase
			end
			case (state_q)
				IDLE: if (s_tvalid) begin
					va_q <= s_tdata[15:0]; vb_q <= s_tdata[31:16];
					ia_q <= s_tdata[47:32]; ib_q <= s_tdata[63:48];
					state_q <= A_FI;
				end
				A_FI: state_q <= A_GD;
				A_GD: begin tmp_q <= mp; state_q <= A_SUM; end
				A_SUM: begin
					est_a_q <= sum16;
					tmp_q <= err_a;
					if ($signed({err_a[15], err_a}) > $signed({2'b00, me_q})) begin
						sl_a_q <= {1'b0, sg_q}; state_q <= B_FI;
					end else if ($signed({err_a[15], err_a}) < neg_me) begin
						sl_a_q <= -$signed({1'b0, sg_q}); state_q <= B_FI;
					end else state_q <= A_LIN;
				end
				A_LIN: state_q <= A_SL;
				A_SL: begin sl_a_q <= mp; state_q <= B_FI; end
				B_FI: begin tmp_q <= '0; state_q <= B_GD; end
				B_GD: begin tmp_q <= mp; state_q <= B_SUM; end
				B_SUM: begin
					est_b_q <= sum16;
					tmp_q <= err_b;
					if ($signed({err_b[15], err_b}) > $signed({2'b00, me_q})) begin
						sl_b_q <= {1'b0, sg_q}; state_q <= E1A;
					end else if ($signed({err_b[15], err_b}) < neg_me) begin
						sl_b_q <= -$signed({1'b0, sg_q}); state_q <= E1A;
					end else state_q <= B_LIN;
				end
				B_LIN: state_q <= B_SL;
				B_SL: begin sl_b_q <= mp; state_q <= E1A; end
				E1A: state_q <= E1A_W;
				E1A_W: begin e1a_q <= e1a_q + mp; state_q <= E2A; end
				E2A: state_q <= E2A_W;
				E2A_W: begin e2a_q <= e2a_q + mp; state_q <= E1B; end
				E1B: state_q <= E1B_W;
				E1B_W: begin e1b_q <= e1b_q + mp; state_q <= E2B; end
				E2B: state_q <= E2B_W;
				E2B_W: begin e2b_q <= e2b_q + mp; state_q <= COR_INIT; end
				COR_INIT: begin
					ci_q <= '0;
					if (e2b_q[15]) begin
						cx_q <= -18'(e2b_q); cy_q <= 18'(e2a_q); cz_q <= 16'h8000;
					end else begin
						cx_q <= 18'(e2b_q); cy_q <= -18'(e2a_q); cz_q <= '0;
					end
					state_q <= COR;
				end
				COR: begin
					if (!cy_q[17]) begin
						cx_q <= cx_q + dx; cy_q <= cy_q - dy;
						cz_q <= cz_q + {2'b00, atan_lut(ci_q)};
					end else begin
						cx_q <= cx_q - dx; cy_q <= cy_q + dy;
						cz_q <= cz_q - {2'b00, atan_lut(ci_q)};
					end
					ci_q <= ci_q + 4'd1;
					if (ci_q == 4'(CordicSteps - 1)) state_q <= SPD;
				end
				SPD: begin
					theta_q <= (e2a_q == 0 && e2b_q == 0) ? 16'sd0 : $signed(cz_q);
					state_q <= SPD_W;
				end
				SPD_W: state_q <= SPF;
				SPF: state_q <= SPF_W;
				SPF_W: begin splp_q <= splp_q + mp; state_q <= CO; end
				CO: state_q <= CO_W;
				CO_W: begin
					coef_q <= (mp < $signed({1'b0, mc_q})) ? $signed({1'b0, mc_q}) : mp;
					state_q <= DONE;
				end
				DONE: if (m_tready) state_q <= IDLE;
				default: ;
			endcase
			// speed window bookkeeping runs in SPD_W, once theta is settled
			if (state_q == SPD_W) begin
				last_q <= theta_q;
				if (win_q + 16'd1 == 16'(SpeedWindow)) begin
					spr_q <= nsum; asum_q <= '0; win_q <= '0;
				end else begin
					asum_q <= nsum; win_q <= win_q + 16'd1;
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== src/smo_checker.sv =====
`default_nettype none
module smo_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [63:0] m_tdata
);
	a_excl: assert property (@(posedge clk) disable iff (!arst_n) !(s_tready && m_tvalid))
		else $error("ready while result pending");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("accepted item while busy");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped");
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready |=> s_tready)
		else $error("not ready after result");
endmodule

bind sliding_mode_rotor_angle_observer_unit smo_checker u_chk (.*);
`default_nettype wire
